@@ rtl/core/dcc_pkg.sv @@
// Package: shared types and codes for the dependency closure cover block.
package dcc_pkg;

    localparam int FIELD_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int STATUS_W = 3;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_CLOSE = 2'd1;
    localparam logic [1:0] MODE_COVER = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRIVIAL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MERGED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FIELD_W-1:0] left_set;
        logic [FIELD_W-1:0] right_set;
        logic [INDEX_W-1:0] index;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0]  result_set;
        logic [FIELD_W-1:0]  entry_left;
        logic [FIELD_W-1:0]  entry_right;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,      // scan entries for equal left side
        S_INS_CHK,
        S_INS_END,
        S_CL_RD,       // closure pass over the table
        S_CL_CHK,
        S_CL_END,
        S_CV_ENTRY,    // fetch entry k for cover
        S_CV_LOAD,
        S_CV_LBIT,     // try next left bit
        S_CV_LDONE,    // closure of reduced left done
        S_CV_MOVE_RD,  // read last entry
        S_CV_MOVE_WR,
        S_CV_RBIT,
        S_CV_RDONE,
        S_RD_WAIT,
        S_OUT
    } t_state;

    // return codes of a closure run, to the caller state
    typedef enum logic [1:0] {
        RET_QUERY,
        RET_LEFT,
        RET_RIGHT
    } t_ret;

endpackage

@@ rtl/core/dependency_closure_cover.sv @@
// Top level: functional dependency table with add, closure, canonical cover and read.
// The dependency table (left and right sides) sits in one synchronous memory with
// a registered read port; a single sequencer walks it. Add makes one scan for an
// equal left side, then an append if none matched and the table has room. Closure
// makes passes over the table, repeated until no entry grows, so up to count+1
// passes. Canonical cover nests a closure for every left and right attribute it
// tries and restarts after every change. One item is in flight at a time; the
// result is held in an output register and the next item is taken once it has
// been delivered. No clearing pass follows reset: entries past the count are
// never read.
module dependency_closure_cover
    import dcc_pkg::*;
#(
    parameter int ATTR_BITS = 32,
    parameter int TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = (ATTR_BITS > 1) ? $clog2(ATTR_BITS) : 1;
    localparam int UW = (ATTR_BITS < FIELD_W) ? ATTR_BITS : FIELD_W;

    typedef logic [ATTR_BITS-1:0] t_set;

    // table memory: {left, right}
    logic [2*ATTR_BITS-1:0] mem [TABLE_DEPTH];
    logic [2*ATTR_BITS-1:0] r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [2*ATTR_BITS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    t_set rd_left, rd_right;
    assign rd_left  = r_rdata[2*ATTR_BITS-1:ATTR_BITS];
    assign rd_right = r_rdata[ATTR_BITS-1:0];

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;          // scan pointer
    logic [CW-1:0] r_ek, n_ek;        // cover entry
    logic [BW-1:0] r_bit, n_bit;
    t_set r_acc, n_acc;
    logic r_grew, n_grew;
    logic r_hit, n_hit;
    t_set r_lhs, n_lhs, r_rhs, n_rhs; // insert operands (also the reduced dependency from cover)
    t_set r_cl, n_cl;                 // cover entry sides
    t_set r_cr, n_cr;
    logic r_cover, n_cover;           // insert issued from cover
    t_out_beat r_out, n_out;
    logic r_oval, n_oval;

    function automatic t_set widen(input logic [FIELD_W-1:0] v);
        t_set s;
        s = '0;
        s[UW-1:0] = v[UW-1:0];
        return s;
    endfunction

    function automatic logic [FIELD_W-1:0] narrow(input t_set v);
        logic [FIELD_W-1:0] f;
        f = '0;
        f[UW-1:0] = v[UW-1:0];
        return f;
    endfunction

    t_set bitmask;
    assign bitmask = t_set'(1) << r_bit;
    logic last_bit;
    assign last_bit = (r_bit == BW'(ATTR_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        n_ret = r_ret; n_count = r_count; n_k = r_k; n_ek = r_ek; n_bit = r_bit;
        n_acc = r_acc; n_grew = r_grew; n_hit = r_hit; n_lhs = r_lhs; n_rhs = r_rhs;
        n_cl = r_cl; n_cr = r_cr; n_cover = r_cover;
        n_out = r_out; n_oval = r_oval;
        mem_we = 1'b0; mem_waddr = r_k[AW-1:0]; mem_wdata = '0;
        mem_raddr = r_k[AW-1:0];
        if (r_oval && i_ready) n_oval = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_oval) begin
                    n_out = '0;
                    n_k = '0;
                    n_lhs = widen(i_data.left_set);
                    n_rhs = widen(i_data.right_set) & ~widen(i_data.left_set);
                    n_cover = 1'b0;
                    case (i_data.mode)
                        MODE_ADD: begin
                            n_hit = 1'b0;
                            if ((widen(i_data.right_set) & ~widen(i_data.left_set)) == '0) begin
                                n_out.status = ST_TRIVIAL;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        MODE_CLOSE: begin
                            n_acc = widen(i_data.left_set);
                            n_grew = 1'b0;
                            n_ret = RET_QUERY;
                            n_state = S_CL_RD;
                        end
                        MODE_COVER: begin
                            n_ek = '0;
                            n_state = S_CV_ENTRY;
                        end
                        default: begin
                            if (CW'(i_data.index) < r_count
                                && 32'(i_data.index) < TABLE_DEPTH) begin
                                mem_raddr = AW'(i_data.index);
                                n_state = S_RD_WAIT;
                            end else begin
                                n_out.status = ST_BAD_INDEX;
                                n_state = S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_out.entry_left = narrow(rd_left);
                n_out.entry_right = narrow(rd_right);
                n_state = S_OUT;
            end
            // insert: r_lhs, r_rhs holds extra (nonzero)
            S_INS_RD: begin
                if (r_k < r_count) begin
                    n_state = S_INS_CHK;
                end else begin
                    n_state = S_INS_END;
                end
            end
            S_INS_CHK: begin
                if (rd_left == r_lhs) begin
                    n_hit = 1'b1;
                    mem_we = 1'b1;
                    mem_wdata = {rd_left, rd_right | r_rhs};
                end
                n_k = r_k + 1'b1;
                mem_raddr = n_k[AW-1:0];
                n_state = S_INS_RD;
            end
            S_INS_END: begin
                if (r_hit) begin
                    n_out.status = ST_MERGED;
                end else if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_out.status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = {r_lhs, r_rhs};
                    n_count = r_count + 1'b1;
                    n_out.status = ST_OK;
                end
                if (r_cover) begin
                    n_ek = '0;
                    n_state = S_CV_ENTRY;
                end else begin
                    n_out.entry_count = (r_hit || r_count >= CW'(TABLE_DEPTH))
                        ? COUNT_W'(r_count) : COUNT_W'(r_count + 1'b1);
                    n_state = S_OUT;
                end
            end
            // closure pass: read address r_k is presented here, its data is checked in S_CL_CHK
            S_CL_RD: begin
                if (r_k < r_count) begin
                    n_state = S_CL_CHK;
                end else begin
                    n_state = S_CL_END;
                end
            end
            S_CL_CHK: begin
                if ((rd_left & ~r_acc) == '0 && (rd_right & ~r_acc) != '0) begin
                    n_acc = r_acc | rd_right;
                    n_grew = 1'b1;
                end
                n_k = r_k + 1'b1;
                mem_raddr = n_k[AW-1:0];
                n_state = S_CL_RD;
            end
            S_CL_END: begin
                n_k = '0;
                mem_raddr = '0;
                if (r_grew) begin
                    n_grew = 1'b0;
                    n_state = S_CL_RD;
                end else begin
                    case (r_ret)
                        RET_QUERY: begin
                            n_out.result_set = narrow(r_acc);
                            n_state = S_OUT;
                        end
                        RET_LEFT: n_state = S_CV_LDONE;
                        default: n_state = S_CV_RDONE;
                    endcase
                end
            end
            // cover: entry r_ek
            S_CV_ENTRY: begin
                mem_raddr = r_ek[AW-1:0];
                if (r_ek < r_count) begin
                    n_state = S_CV_LOAD;
                end else begin
                    n_out.status = ST_OK;
                    n_state = S_OUT;
                end
            end
            S_CV_LOAD: begin
                n_cl = rd_left;
                n_cr = rd_right;
                n_bit = '0;
                n_state = S_CV_LBIT;
            end
            S_CV_LBIT: begin
                if ((r_cl & bitmask) != '0) begin
                    n_acc = r_cl & ~bitmask;
                    n_grew = 1'b0;
                    n_k = '0;
                    mem_raddr = '0;
                    n_ret = RET_LEFT;
                    n_state = S_CL_RD;
                end else if (last_bit) begin
                    n_bit = '0;
                    n_state = S_CV_RBIT;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            S_CV_LDONE: begin
                if ((r_cr & ~r_acc) == '0) begin
                    // drop the entry, re-add the reduced dependency
                    n_lhs = r_cl & ~bitmask;
                    n_rhs = r_cr & ~(r_cl & ~bitmask);
                    n_count = r_count - 1'b1;
                    mem_raddr = n_count[AW-1:0];
                    n_state = S_CV_MOVE_RD;
                end else if (last_bit) begin
                    n_bit = '0;
                    n_state = S_CV_RBIT;
                end else begin
                    n_bit = r_bit + 1'b1;
                    n_state = S_CV_LBIT;
                end
            end
            S_CV_MOVE_RD: begin
                // hold the last entry on the read port
                mem_raddr = r_count[AW-1:0];
                n_state = S_CV_MOVE_WR;
            end
            S_CV_MOVE_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_ek[AW-1:0];
                mem_wdata = r_rdata;
                n_k = '0;
                n_hit = 1'b0;
                n_cover = 1'b1;
                mem_raddr = '0;
                if (r_rhs == '0) begin
                    n_ek = '0;
                    n_state = S_CV_ENTRY;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_CV_RBIT: begin
                if ((r_cr & bitmask) != '0) begin
                    // tentatively drop the bit
                    mem_we = 1'b1;
                    mem_waddr = r_ek[AW-1:0];
                    mem_wdata = {r_cl, r_cr & ~bitmask};
                    n_acc = r_cl;
                    n_grew = 1'b0;
                    n_k = '0;
                    n_ret = RET_RIGHT;
                    n_state = S_CL_RD;
                end else if (last_bit) begin
                    n_ek = r_ek + 1'b1;
                    n_state = S_CV_ENTRY;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            S_CV_RDONE: begin
                if ((r_acc & bitmask) != '0) begin
                    n_cr = r_cr & ~bitmask;
                    n_ek = '0;
                    n_state = S_CV_ENTRY;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = r_ek[AW-1:0];
                    mem_wdata = {r_cl, r_cr};
                    if (last_bit) begin
                        n_ek = r_ek + 1'b1;
                        n_state = S_CV_ENTRY;
                    end else begin
                        n_bit = r_bit + 1'b1;
                        n_state = S_CV_RBIT;
                    end
                end
            end
            S_OUT: begin
                n_out.entry_count = COUNT_W'(r_count);
                n_oval = 1'b1;
                n_cover = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_oval <= 1'b0;
            r_cover <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oval <= n_oval;
            r_cover <= n_cover;
        end
        r_ret <= n_ret; r_k <= n_k; r_ek <= n_ek; r_bit <= n_bit; r_acc <= n_acc;
        r_grew <= n_grew; r_hit <= n_hit; r_lhs <= n_lhs; r_rhs <= n_rhs;
        r_cl <= n_cl; r_cr <= n_cr; r_out <= n_out;
    end

    // outputs
    assign o_ready = (r_state == S_IDLE) && !r_oval;
    assign o_valid = r_oval;
    assign o_data = r_out;

endmodule

@@ tb/sv/tb_dependency_closure_cover.sv @@
// Testbench for the dependency closure cover block: directed table, then random beats.
`timescale 1ns / 100ps

module tb_dependency_closure_cover
    import dcc_pkg::*;
();

    localparam int DEPTH = 16;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 64'd200_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    dependency_closure_cover #(
        .ATTR_BITS(32),
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Predictor state: our own copy of the dependency table.
    logic [31:0] dep_left [DEPTH];
    logic [31:0] dep_right[DEPTH];
    int          dep_count;

    t_out_beat   pending_results[$];
    int          error_count;
    longint      cycle_count;
    bit          stim_done;
    bit          long_hold;

    function automatic logic [31:0] closure_of(logic [31:0] start);
        logic [31:0] acc;
        bit          grew;
        acc = start;
        do begin
            grew = 0;
            for (int k = 0; k < dep_count; k++) begin
                if ((dep_left[k] & ~acc) == 0 && (dep_right[k] & ~acc) != 0) begin
                    acc |= dep_right[k];
                    grew = 1;
                end
            end
        end while (grew);
        return acc;
    endfunction

    function automatic logic [2:0] insert_dep(logic [31:0] lhs, logic [31:0] rhs);
        logic [31:0] extra;
        bit          hit;
        extra = rhs & ~lhs;
        hit = 0;
        if (extra == 0) return ST_TRIVIAL;
        for (int k = 0; k < dep_count; k++) begin
            if (dep_left[k] == lhs) begin
                dep_right[k] |= extra;
                hit = 1;
            end
        end
        if (hit) return ST_MERGED;
        if (dep_count >= DEPTH) return ST_FULL;
        dep_left[dep_count] = lhs;
        dep_right[dep_count] = extra;
        dep_count++;
        return ST_OK;
    endfunction

    // Canonical cover: restart from entry 0 after every change.
    function automatic void reduce_cover();
        bit          changed;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] bitm;
        logic [31:0] smaller;
        do begin
            changed = 0;
            for (int k = 0; k < dep_count && !changed; k++) begin
                lhs = dep_left[k];
                rhs = dep_right[k];
                for (int b = 0; b < 32 && !changed; b++) begin
                    bitm = 32'd1 << b;
                    if ((lhs & bitm) != 0) begin
                        smaller = lhs & ~bitm;
                        if ((rhs & ~closure_of(smaller)) == 0) begin
                            dep_left[k] = dep_left[dep_count-1];
                            dep_right[k] = dep_right[dep_count-1];
                            dep_count--;
                            void'(insert_dep(smaller, rhs));
                            changed = 1;
                        end
                    end
                end
                for (int b = 0; b < 32 && !changed; b++) begin
                    bitm = 32'd1 << b;
                    if ((rhs & bitm) != 0) begin
                        dep_right[k] &= ~bitm;
                        if ((closure_of(lhs) & bitm) != 0) changed = 1;
                        else dep_right[k] |= bitm;
                    end
                end
            end
        end while (changed);
    endfunction

    function automatic t_out_beat predict_beat(t_in_beat b);
        t_out_beat r;
        r = '0;
        case (b.mode)
            MODE_ADD:   r.status = insert_dep(b.left_set, b.right_set);
            MODE_CLOSE: r.result_set = closure_of(b.left_set);
            MODE_COVER: reduce_cover();
            default: begin
                if (b.index < dep_count) begin
                    r.entry_left = dep_left[b.index];
                    r.entry_right = dep_right[b.index];
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
        endcase
        r.entry_count = dep_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Directed table. Expected result is typed in where obvious; known=0
    // rows go through the predictor.
    typedef struct {
        t_in_beat  beat;
        bit        known;
        t_out_beat want;
    } t_row;
    t_row directed[$];

    function automatic t_in_beat mk(logic [1:0] m, logic [31:0] l, logic [31:0] r,
                                    logic [3:0] ix);
        t_in_beat b;
        b.mode = m; b.left_set = l; b.right_set = r; b.index = ix;
        return b;
    endfunction

    function automatic t_out_beat res(logic [31:0] rs, logic [31:0] el, logic [31:0] er,
                                      logic [4:0] c, logic [2:0] s);
        t_out_beat o;
        o.result_set = rs; o.entry_left = el; o.entry_right = er;
        o.entry_count = c; o.status = s;
        return o;
    endfunction

    task automatic add_row(t_in_beat b, bit k, t_out_beat w);
        t_row r;
        r.beat = b; r.known = k; r.want = w;
        directed = {directed, r};
    endtask

    task automatic build_directed();
        // empty table after reset
        add_row(mk(MODE_READ, 0, 0, 4'd0), 1, res(0, 0, 0, 0, ST_BAD_INDEX));
        add_row(mk(MODE_CLOSE, 32'hFFFF_FFFF, 0, 0), 1, res(32'hFFFF_FFFF, 0, 0, 0, ST_OK));
        add_row(mk(MODE_COVER, 0, 0, 0), 1, res(0, 0, 0, 0, ST_OK));
        // trivial adds
        add_row(mk(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, res(0, 0, 0, 0, ST_TRIVIAL));
        add_row(mk(MODE_ADD, 32'h0000_0003, 32'h0, 0), 1, res(0, 0, 0, 0, ST_TRIVIAL));
        // append, merge, extremes
        add_row(mk(MODE_ADD, 32'h0000_0001, 32'h0000_0003, 0), 1,
                res(0, 0, 0, 1, ST_OK));
        add_row(mk(MODE_READ, 0, 0, 4'd0), 1, res(0, 32'h1, 32'h2, 1, ST_OK));
        add_row(mk(MODE_ADD, 32'h0000_0001, 32'h8000_0000, 0), 1,
                res(0, 0, 0, 1, ST_MERGED));
        add_row(mk(MODE_ADD, 32'h0, 32'hFFFF_FFFF, 0), 1, res(0, 0, 0, 2, ST_OK));
        add_row(mk(MODE_READ, 0, 0, 4'd1), 1, res(0, 0, 32'hFFFF_FFFF, 2, ST_OK));
        add_row(mk(MODE_READ, 0, 0, 4'd2), 1, res(0, 0, 0, 2, ST_BAD_INDEX));
        add_row(mk(MODE_READ, 0, 0, 4'd15), 1, res(0, 0, 0, 2, ST_BAD_INDEX));
        add_row(mk(MODE_CLOSE, 32'h0, 0, 0), 0, '0);
        add_row(mk(MODE_ADD, 32'h0000_0006, 32'h0000_0018, 0), 0, '0);
        add_row(mk(MODE_ADD, 32'h0000_0002, 32'h0000_0010, 0), 0, '0);
        add_row(mk(MODE_COVER, 0, 0, 0), 0, '0);
        add_row(mk(MODE_READ, 0, 0, 4'd0), 0, '0);
        add_row(mk(MODE_READ, 0, 0, 4'd1), 0, '0);
        add_row(mk(MODE_READ, 0, 0, 4'd2), 0, '0);
        // fill the table to the full case
        for (int i = 0; i < 16; i++)
            add_row(mk(MODE_ADD, 32'h1000_0000 << (i % 4) | (i << 8), 32'h0004_0000 << i, 0),
                    0, '0);
        add_row(mk(MODE_READ, 0, 0, 4'd15), 0, '0);
    endtask

    // Random beats: small attribute universe so dependencies chain.
    function automatic logic [31:0] rand_set(int sel);
        logic [31:0] v;
        case (sel)
            0: v = $urandom();
            1: v = $urandom() & $urandom() & $urandom();
            default: v = $urandom() & 32'h0000_00FF & ($urandom() | $urandom());
        endcase
        return v;
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        int p;
        int sel;
        p = $urandom_range(0, 99);
        sel = ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2);
        b.left_set = rand_set(sel);
        b.right_set = rand_set(sel);
        b.index = 4'($urandom());
        if (p < 45) b.mode = MODE_ADD;
        else if (p < 75) b.mode = MODE_CLOSE;
        else if (p < 82) b.mode = MODE_COVER;
        else b.mode = MODE_READ;
        return b;
    endfunction

    // Sender: bursts with gaps. Predictor runs when the beat is accepted.
    t_in_beat   stim_q[$];
    t_out_beat  known_q[$];
    bit         known_flag[$];

    initial begin
        int burst;
        int gap;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        error_count = 0;
        stim_done = 0;
        dep_count = 0;
        build_directed();
        foreach (directed[i]) begin
            stim_q = {stim_q, directed[i].beat};
            known_flag = {known_flag, directed[i].known};
            known_q = {known_q, directed[i].want};
        end
        repeat (N_RANDOM) begin
            stim_q = {stim_q, rand_beat()};
            known_flag = {known_flag, 1'b0};
            known_q = {known_q, t_out_beat'('0)};
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 20);
            end
            i_valid <= 1'b1;
            i_data <= stim_q[0];
            do @(posedge i_clk); while (!(i_valid && o_ready));
            begin
                t_out_beat p;
                p = predict_beat(stim_q[0]);
                if (known_flag[0])
                    pending_results = {pending_results, known_q[0]};
                else
                    pending_results = {pending_results, p};
            end
            void'(stim_q.pop_front());
            void'(known_flag.pop_front());
            void'(known_q.pop_front());
            burst--;
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    // Long hold-off: receiver stalls for a while so the block backs up.
    initial begin
        int hold;
        long_hold = 0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        long_hold = 1;
        hold = 0;
        while (hold < 3000) begin
            @(posedge i_clk);
            hold++;
        end
        long_hold = 0;
    end

    // Receiver stall pattern, independent of the sender.
    initial begin
        int phase;
        i_ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase = (phase + 1) % 23;
            if (long_hold) i_ready <= 1'b0;
            else if (phase < 8) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker: compare each accepted beat field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", o_data.result_set, 0);
            end else begin
                t_out_beat w;
                w = pending_results.pop_front();
                if (o_data.result_set !== w.result_set)
                    report_mismatch("result_set", o_data.result_set, w.result_set);
                if (o_data.entry_left !== w.entry_left)
                    report_mismatch("entry_left", o_data.entry_left, w.entry_left);
                if (o_data.entry_right !== w.entry_right)
                    report_mismatch("entry_right", o_data.entry_right, w.entry_right);
                if (o_data.entry_count !== w.entry_count)
                    report_mismatch("entry_count", 32'(o_data.entry_count), 32'(w.entry_count));
                if (o_data.status !== w.status)
                    report_mismatch("status", 32'(o_data.status), 32'(w.status));
            end
        end
    end

    // End of run and timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout at cycle %0d", cycle_count);
                $display("FAIL dependency_closure_cover");
                $finish;
            end
            if (stim_done && pending_results.size() == 0) begin
                repeat (100) @(posedge i_clk);
                if (error_count == 0 && pending_results.size() == 0) begin
                    $display("PASS dependency_closure_cover");
                end else begin
                    $display("FAIL dependency_closure_cover");
                end
                $finish;
            end
        end
    end

endmodule
